/* hw/rtl/bfx_pkg.sv */
// Shared constants, command codes and controller/datapath interface types.
`default_nettype none

package bfx_pkg;

    // Store sizes
    localparam int PROG_DEPTH = 4096;
    localparam int TAPE_DEPTH = 1024;

    // Derived index and position widths
    localparam int PA_W = $clog2(PROG_DEPTH);
    localparam int TA_W = $clog2(TAPE_DEPTH);
    localparam int PC_W = $clog2(PROG_DEPTH + 1);

    // Fixed port field widths
    localparam int LEN_W      = 13;
    localparam int POS_W      = 13;
    localparam int HEAD_W     = 10;
    localparam int CELL_W     = 8;
    localparam int KIND_W     = 2;
    localparam int ADDR_W     = 12;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXEC    = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_UNDER   = 2'd1;
    localparam logic [ST_W-1:0] ST_OVER    = 2'd2;
    localparam logic [ST_W-1:0] ST_BRACKET = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_INIT = 1'd1;

    // Command characters
    localparam logic [CELL_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CELL_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CELL_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CELL_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CELL_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [CELL_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [CELL_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [CELL_W-1:0] CH_CLOSE = 8'h5D;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic prog_wr;
        logic restart;
        logic fill_step;
        logic exec;
        logic cell_load;
        logic sel_scan;
        logic scan_step;
        logic scan_fail;
        logic load_result;
    } bfx_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              done;
        logic              need_scan;
        logic              need_cell;
        logic              scan_out;
        logic              scan_hit;
        logic              fill_last;
        logic              res_free;
    } bfx_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/bfx_datapath.sv */
// Datapath: program store, tape memory, pc/head/error registers, bracket scan, result register.
`default_nettype none

module bfx_datapath
    import bfx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [ADDR_W-1:0]     address,
    input  wire logic [CELL_W-1:0]     instr_byte,
    input  wire logic [CELL_W-1:0]     in_byte,
    input  wire bfx_cmd_t              cmd,
    output bfx_stat_t                  stat,
    input  wire logic                  res_ready,
    output logic                       res_valid,
    output logic                       out_valid,
    output logic [CELL_W-1:0]          out_byte,
    output logic                       input_taken,
    output logic                       done_res,
    output logic [ST_W-1:0]            status,
    output logic [POS_W-1:0]           position,
    output logic [HEAD_W-1:0]          head,
    output logic [CELL_W-1:0]          cell_value
);

    // Memories
    logic [CELL_W-1:0] prog_mem [PROG_DEPTH];
    logic [CELL_W-1:0] tape_mem [TAPE_DEPTH];
    logic [CELL_W-1:0] prog_rdata_reg;
    logic [CELL_W-1:0] tape_rdata_reg;

    // Architectural state
    logic [PC_W-1:0]   pc_reg;
    logic [TA_W-1:0]   head_reg;
    logic [ST_W-1:0]   err_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [LEN_W-1:0]  prog_len_reg;
    logic [CELL_W-1:0] cell_init_reg;
    logic [CELL_W-1:0] fill_val_reg;
    logic [TA_W-1:0]   fill_cnt_reg;

    // Per-word flags and latched input
    logic              ov_reg;
    logic [CELL_W-1:0] ob_reg;
    logic              taken_reg;
    logic [CELL_W-1:0] in_byte_reg;

    // Bracket scan
    logic              scan_fwd_reg;
    logic [PC_W-1:0]   scan_addr_reg;
    logic [PC_W-1:0]   depth_reg;

    // Result word
    logic              res_valid_reg;
    logic              res_ov_reg;
    logic [CELL_W-1:0] res_ob_reg;
    logic              res_taken_reg;
    logic              res_done_reg;
    logic [ST_W-1:0]   res_st_reg;
    logic [POS_W-1:0]  res_pos_reg;
    logic [HEAD_W-1:0] res_head_reg;
    logic [CELL_W-1:0] res_cell_reg;

    logic [PC_W-1:0]   eff_len;
    logic              done;
    logic [PA_W-1:0]   prog_raddr;
    logic [TA_W-1:0]   tape_raddr;
    logic              tape_we;
    logic [TA_W-1:0]   tape_waddr;
    logic [CELL_W-1:0] tape_wdata;

    // Decode results
    logic              ex_adv;
    logic              ex_wr;
    logic [CELL_W-1:0] ex_wdata;
    logic [ST_W-1:0]   ex_err;
    logic [TA_W-1:0]   ex_head;
    logic              ex_scan;
    logic              ex_cell;
    logic              ex_ov;
    logic              ex_taken;

    logic              is_open;
    logic              is_close;
    logic              nest_in;
    logic              nest_out;
    logic              scan_hit;

    // Effective length and done flag
    always_comb
    begin
        if (32'(prog_len_reg) > PROG_DEPTH)
            eff_len = PC_W'(PROG_DEPTH);
        else
            eff_len = PC_W'(prog_len_reg);
    end

    assign done = (err_reg != ST_OK) || (pc_reg >= eff_len);

    // Instruction decode
    always_comb
    begin
        ex_adv   = 1'b1;
        ex_wr    = 1'b0;
        ex_wdata = cell_reg;
        ex_err   = ST_OK;
        ex_head  = head_reg;
        ex_scan  = 1'b0;
        ex_cell  = 1'b0;
        ex_ov    = 1'b0;
        ex_taken = 1'b0;
        unique case (prog_rdata_reg)
            CH_PLUS:
            begin
                ex_wr    = 1'b1;
                ex_wdata = cell_reg + CELL_W'(1);
            end
            CH_MINUS:
            begin
                ex_wr    = 1'b1;
                ex_wdata = cell_reg - CELL_W'(1);
            end
            CH_DOT:
            begin
                ex_ov = 1'b1;
            end
            CH_COMMA:
            begin
                ex_wr    = 1'b1;
                ex_wdata = in_byte_reg;
                ex_taken = 1'b1;
            end
            CH_RIGHT:
            begin
                if (head_reg == TA_W'(TAPE_DEPTH - 1))
                begin
                    ex_err = ST_OVER;
                    ex_adv = 1'b0;
                end
                else
                begin
                    ex_head = head_reg + TA_W'(1);
                    ex_cell = 1'b1;
                end
            end
            CH_LEFT:
            begin
                if (head_reg == '0)
                begin
                    ex_err = ST_UNDER;
                    ex_adv = 1'b0;
                end
                else
                begin
                    ex_head = head_reg - TA_W'(1);
                    ex_cell = 1'b1;
                end
            end
            CH_OPEN:
            begin
                if (cell_reg == '0)
                begin
                    ex_scan = 1'b1;
                    ex_adv  = 1'b0;
                end
            end
            CH_CLOSE:
            begin
                if (cell_reg != '0)
                begin
                    ex_scan = 1'b1;
                    ex_adv  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Bracket scan: nesting goes in on a same-direction bracket, out on the other
    assign is_open  = (prog_rdata_reg == CH_OPEN);
    assign is_close = (prog_rdata_reg == CH_CLOSE);
    assign nest_in  = scan_fwd_reg ? is_open : is_close;
    assign nest_out = scan_fwd_reg ? is_close : is_open;
    assign scan_hit = nest_out && (depth_reg == '0);

    // Status to controller
    always_comb
    begin
        stat.kind      = kind;
        stat.done      = done;
        stat.need_scan = ex_scan;
        stat.need_cell = ex_cell;
        stat.scan_out  = scan_fwd_reg ? (scan_addr_reg >= eff_len) : (scan_addr_reg == '1);
        stat.scan_hit  = scan_hit;
        stat.fill_last = (fill_cnt_reg == TA_W'(TAPE_DEPTH - 1));
        stat.res_free  = !res_valid_reg || res_ready;
    end

    // Program store
    assign prog_raddr = cmd.sel_scan ? PA_W'(scan_addr_reg) : PA_W'(pc_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.prog_wr && (32'(address) < PROG_DEPTH))
            prog_mem[PA_W'(address)] <= instr_byte;
        prog_rdata_reg <= prog_mem[prog_raddr];
    end

    // Tape memory: fill sweep or instruction write, read at the head to come
    always_comb
    begin
        tape_we    = 1'b0;
        tape_waddr = head_reg;
        tape_wdata = ex_wdata;
        if (cmd.fill_step)
        begin
            tape_we    = 1'b1;
            tape_waddr = fill_cnt_reg;
            tape_wdata = fill_val_reg;
        end
        else if (cmd.exec && ex_wr)
        begin
            tape_we = 1'b1;
        end
    end

    assign tape_raddr = cmd.exec ? ex_head : head_reg;

    always_ff @(posedge clk)
    begin
        if (tape_we)
            tape_mem[tape_waddr] <= tape_wdata;
        tape_rdata_reg <= tape_mem[tape_raddr];
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            head_reg      <= '0;
            err_reg       <= ST_OK;
            cell_reg      <= '0;
            prog_len_reg  <= '0;
            cell_init_reg <= '0;
            fill_val_reg  <= '0;
            fill_cnt_reg  <= '0;
            ov_reg        <= 1'b0;
            ob_reg        <= '0;
            taken_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PROG_LEN:  prog_len_reg  <= cfg_data[LEN_W-1:0];
                    CFG_CELL_INIT: cell_init_reg <= cfg_data[CELL_W-1:0];
                    default:       prog_len_reg  <= prog_len_reg;
                endcase
            end
            if (cmd.capture)
            begin
                ov_reg    <= 1'b0;
                ob_reg    <= '0;
                taken_reg <= 1'b0;
            end
            if (cmd.restart)
            begin
                pc_reg       <= '0;
                head_reg     <= '0;
                err_reg      <= ST_OK;
                fill_val_reg <= cell_init_reg;
                fill_cnt_reg <= '0;
            end
            if (cmd.fill_step)
            begin
                fill_cnt_reg <= fill_cnt_reg + TA_W'(1);
                if (stat.fill_last)
                    cell_reg <= fill_val_reg;
            end
            if (cmd.exec)
            begin
                if (ex_adv)
                    pc_reg <= pc_reg + PC_W'(1);
                head_reg  <= ex_head;
                err_reg   <= ex_err;
                ov_reg    <= ex_ov;
                ob_reg    <= ex_ov ? cell_reg : '0;
                taken_reg <= ex_taken;
                if (ex_wr)
                    cell_reg <= ex_wdata;
            end
            if (cmd.cell_load)
                cell_reg <= tape_rdata_reg;
            if (cmd.scan_step && scan_hit)
                pc_reg <= scan_addr_reg + PC_W'(1);
            if (cmd.scan_fail)
                err_reg <= ST_BRACKET;
            // Result word handshake
            if (cmd.load_result)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_byte_reg <= in_byte;
        if (cmd.exec && ex_scan)
        begin
            scan_fwd_reg  <= (prog_rdata_reg == CH_OPEN);
            scan_addr_reg <= (prog_rdata_reg == CH_OPEN) ? pc_reg + PC_W'(1)
                                                        : pc_reg - PC_W'(1);
            depth_reg     <= '0;
        end
        if (cmd.scan_step && !scan_hit)
        begin
            if (nest_in)
                depth_reg <= depth_reg + PC_W'(1);
            else if (nest_out)
                depth_reg <= depth_reg - PC_W'(1);
            scan_addr_reg <= scan_fwd_reg ? scan_addr_reg + PC_W'(1)
                                          : scan_addr_reg - PC_W'(1);
        end
        if (cmd.load_result)
        begin
            res_ov_reg    <= ov_reg;
            res_ob_reg    <= ob_reg;
            res_taken_reg <= taken_reg;
            res_done_reg  <= done;
            res_st_reg    <= err_reg;
            res_pos_reg   <= POS_W'(pc_reg);
            res_head_reg  <= HEAD_W'(head_reg);
            res_cell_reg  <= cell_reg;
        end
    end

    assign res_valid   = res_valid_reg;
    assign out_valid   = res_ov_reg;
    assign out_byte    = res_ob_reg;
    assign input_taken = res_taken_reg;
    assign done_res    = res_done_reg;
    assign status      = res_st_reg;
    assign position    = res_pos_reg;
    assign head        = res_head_reg;
    assign cell_value  = res_cell_reg;

endmodule

`default_nettype wire

/* hw/rtl/bfx_controller.sv */
// Controller: state machine sequencing load, restart fill, execute and bracket scan.
`default_nettype none

module bfx_controller
    import bfx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire bfx_stat_t stat,
    output bfx_cmd_t       cmd
);

    localparam logic [2:0] S_FILL     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_FETCH    = 3'd2;
    localparam logic [2:0] S_DECODE   = 3'd3;
    localparam logic [2:0] S_CELL     = 3'd4;
    localparam logic [2:0] S_SCAN_RD  = 3'd5;
    localparam logic [2:0] S_SCAN_CHK = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       fill_res_reg;
    logic       fill_res_next;

    // Next state and commands
    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        fill_res_next = fill_res_reg;
        in_ready      = (state_reg == S_IDLE);
        unique case (state_reg)
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    state_next    = fill_res_reg ? S_FINISH : S_IDLE;
                    fill_res_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (stat.kind)
                        KIND_LOAD:
                        begin
                            cmd.prog_wr = 1'b1;
                            state_next  = S_FINISH;
                        end
                        KIND_RESTART:
                        begin
                            cmd.restart   = 1'b1;
                            fill_res_next = 1'b1;
                            state_next    = S_FILL;
                        end
                        KIND_EXEC:
                        begin
                            state_next = stat.done ? S_FINISH : S_FETCH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cmd.exec = 1'b1;
                if (stat.need_scan)
                    state_next = S_SCAN_RD;
                else if (stat.need_cell)
                    state_next = S_CELL;
                else
                    state_next = S_FINISH;
            end
            S_CELL:
            begin
                cmd.cell_load = 1'b1;
                state_next    = S_FINISH;
            end
            S_SCAN_RD:
            begin
                cmd.sel_scan = 1'b1;
                if (stat.scan_out)
                begin
                    cmd.scan_fail = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.scan_step = 1'b1;
                state_next    = stat.scan_hit ? S_FINISH : S_SCAN_RD;
            end
            S_FINISH:
            begin
                if (stat.res_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers; reset starts the tape clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_FILL;
            fill_res_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_res_reg <= fill_res_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/bf_instruction_executor_core.sv */
// Top level of the Brainfuck execution core: controller plus datapath.
`default_nettype none

// Brainfuck execution core. Input words are load (write one program byte),
// restart (clear pc, head and error, fill the tape with cell_init) or execute
// (run one instruction); every input word returns exactly one result word.
// Steps from acceptance to result valid: load and no-op kinds, and an execute
// that is already done, go straight to the result load; most instructions
// pass accept, program store read, decode with tape write and result load;
// '>' and '<' that move the head add a tape read of the new cell; a taken
// bracket jump walks the program store read port, reading and then checking
// one program byte at a time, and ends with a bracket error if none matches.
// Restart runs the tape fill sweep, one cell per cycle, before its result.
// After reset the same sweep runs with in_ready low; configuration writes
// are taken at any time and belong between words, while nothing is in flight.
// The next input word can be accepted while the previous result still waits
// on res_ready.
module bf_instruction_executor_core
    import bfx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [ADDR_W-1:0]     address,
    input  wire logic [CELL_W-1:0]     instr_byte,
    input  wire logic [CELL_W-1:0]     in_byte,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic                       out_valid,
    output logic [CELL_W-1:0]          out_byte,
    output logic                       input_taken,
    output logic                       done_res,
    output logic [ST_W-1:0]            status,
    output logic [POS_W-1:0]           position,
    output logic [HEAD_W-1:0]          head,
    output logic [CELL_W-1:0]          cell_value
);

    bfx_cmd_t  cmd;
    bfx_stat_t stat;

    bfx_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfx_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .address     (address),
        .instr_byte  (instr_byte),
        .in_byte     (in_byte),
        .cmd         (cmd),
        .stat        (stat),
        .res_ready   (res_ready),
        .res_valid   (res_valid),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .input_taken (input_taken),
        .done_res    (done_res),
        .status      (status),
        .position    (position),
        .head        (head),
        .cell_value  (cell_value)
    );

endmodule

`default_nettype wire

/* hw/rtl/bfx_checker.sv */
// Port-level checker for the execution core, bound to the top level.
`default_nettype none

module bfx_checker
    import bfx_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  res_valid,
    input wire logic                  res_ready,
    input wire logic                  out_valid,
    input wire logic [CELL_W-1:0]     out_byte,
    input wire logic                  input_taken,
    input wire logic                  done_res,
    input wire logic [ST_W-1:0]       status,
    input wire logic [POS_W-1:0]      position,
    input wire logic [CELL_W-1:0]     cell_value
);

    // A stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(position) && $stable(cell_value))
        else $error("result word changed while stalled");

    // Any error status means the core reports done
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status == ST_OK) || done_res)
        else $error("error status without done");

    // One instruction cannot both print and read
    a_io_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(out_valid && input_taken))
        else $error("output and input in the same word");

    // No output byte without a period
    a_ob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_byte == '0)
        else $error("out_byte nonzero without output");

    // One input word at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind bf_instruction_executor_core bfx_checker u_bfx_checker (.*);

`default_nettype wire

/* dv/bf_instruction_executor_core_test.sv */
// Self-checking testbench for the Brainfuck execution core with a shadow model.
module bf_instruction_executor_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bfx_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;   // unused kind, only reports state
    localparam int STALL_LIMIT  = 40000;
    localparam int RANDOM_WORK  = 1150;
    localparam int SHOW_LIMIT   = 10;
    localparam int LEN_FIELD_MAX = (1 << LEN_W) - 1;

    // One result word, in port order
    typedef struct packed {
        logic              out_valid;
        logic [CELL_W-1:0] out_byte;
        logic              input_taken;
        logic              done_res;
        logic [ST_W-1:0]   status;
        logic [POS_W-1:0]  position;
        logic [HEAD_W-1:0] head;
        logic [CELL_W-1:0] cell_value;
    } bf_report_t;

    // Shadow of the core: program store, tape, pc, head, error and registers.
    // Each accepted input word is run here and its result word queued.
    class bf_run_tracker;
        bit [7:0]     prog_mem [PROG_DEPTH];
        bit [7:0]     tape_mem [TAPE_DEPTH];
        int           pc;
        int           hd;
        bit [ST_W-1:0] err;
        int           prog_len;
        bit [7:0]     cell_init;
        bf_report_t   due_reports[$];
        int unsigned  fails;

        function int eff_len();
            return (prog_len < PROG_DEPTH) ? prog_len : PROG_DEPTH;
        endfunction

        function bit halted();
            return (err != ST_OK) || (pc >= eff_len());
        endfunction

        function int outstanding();
            return due_reports.size();
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_PROG_LEN)
                prog_len = int'(data);
            else
                cell_init = data[7:0];
        endfunction

        // matching ']' for the '[' at pc, -1 if none inside the length
        function int find_close();
            int depth;
            int a;
            depth = 0;
            for (a = pc + 1; a < eff_len(); a++)
            begin
                if (prog_mem[a] == CH_OPEN)
                    depth++;
                else if (prog_mem[a] == CH_CLOSE)
                begin
                    if (depth == 0)
                        return a;
                    depth--;
                end
            end
            return -1;
        endfunction

        // matching '[' for the ']' at pc, -1 if none
        function int find_open();
            int depth;
            int a;
            depth = 0;
            a = pc;
            while (a > 0)
            begin
                a--;
                if (prog_mem[a] == CH_CLOSE)
                    depth++;
                else if (prog_mem[a] == CH_OPEN)
                begin
                    if (depth == 0)
                        return a;
                    depth--;
                end
            end
            return -1;
        endfunction

        // Run one input word; returns 1 when the word did any work
        function bit take_word(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                               input logic [7:0] ib, input logic [7:0] inb);
            bf_report_t r;
            bit [7:0]   c;
            int         m;
            bit         adv;
            bit         worked;
            r = '0;
            worked = 1'b1;
            case (k)
                KIND_LOAD:
                    prog_mem[a] = ib;
                KIND_RESTART:
                begin
                    foreach (tape_mem[i])
                        tape_mem[i] = cell_init;
                    pc = 0;
                    hd = 0;
                    err = ST_OK;
                end
                KIND_EXEC:
                begin
                    if (halted())
                        worked = 1'b0;
                    else
                    begin
                        c = prog_mem[pc];
                        adv = 1'b1;
                        case (c)
                            CH_PLUS:  tape_mem[hd] = tape_mem[hd] + 8'd1;
                            CH_MINUS: tape_mem[hd] = tape_mem[hd] - 8'd1;
                            CH_DOT:
                            begin
                                r.out_valid = 1'b1;
                                r.out_byte = tape_mem[hd];
                            end
                            CH_COMMA:
                            begin
                                tape_mem[hd] = inb;
                                r.input_taken = 1'b1;
                            end
                            CH_RIGHT:
                            begin
                                if (hd == TAPE_DEPTH - 1)
                                begin
                                    err = ST_OVER;
                                    adv = 1'b0;
                                end
                                else
                                    hd++;
                            end
                            CH_LEFT:
                            begin
                                if (hd == 0)
                                begin
                                    err = ST_UNDER;
                                    adv = 1'b0;
                                end
                                else
                                    hd--;
                            end
                            CH_OPEN:
                            begin
                                if (tape_mem[hd] == 8'd0)
                                begin
                                    m = find_close();
                                    if (m >= 0)
                                        pc = m;
                                    else
                                    begin
                                        err = ST_BRACKET;
                                        adv = 1'b0;
                                    end
                                end
                            end
                            CH_CLOSE:
                            begin
                                if (tape_mem[hd] != 8'd0)
                                begin
                                    m = find_open();
                                    if (m >= 0)
                                        pc = m;
                                    else
                                    begin
                                        err = ST_BRACKET;
                                        adv = 1'b0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                        if (adv)
                            pc++;
                    end
                end
                default:
                    worked = 1'b0;
            endcase
            r.done_res = halted();
            r.status = err;
            r.position = POS_W'(pc);
            r.head = HEAD_W'(hd);
            r.cell_value = tape_mem[hd];
            due_reports.insert(due_reports.size(), r);
            return worked;
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void match_report(input bf_report_t got);
            bf_report_t want;
            if (due_reports.size() == 0)
            begin
                fails++;
                if (fails <= SHOW_LIMIT)
                    $display("%0t: result word with no prediction pending", $time);
                return;
            end
            want = due_reports.pop_front();
            if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
                got.input_taken !== want.input_taken || got.done_res !== want.done_res ||
                got.status !== want.status || got.position !== want.position ||
                got.head !== want.head || got.cell_value !== want.cell_value)
            begin
                fails++;
                if (fails <= SHOW_LIMIT)
                begin
                    $display("%0t: result word mismatch", $time);
                    $display("  expected ov=%0b ob=%02h taken=%0b done=%0b",
                             want.out_valid, want.out_byte, want.input_taken, want.done_res,
                             " st=%0d pos=%0d head=%0d cell=%02h",
                             want.status, want.position, want.head, want.cell_value);
                    $display("  actual   ov=%0b ob=%02h taken=%0b done=%0b",
                             got.out_valid, got.out_byte, got.input_taken, got.done_res,
                             " st=%0d pos=%0d head=%0d cell=%02h",
                             got.status, got.position, got.head, got.cell_value);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [KIND_W-1:0]     kind = '0;
    logic [ADDR_W-1:0]     address = '0;
    logic [CELL_W-1:0]     instr_byte = '0;
    logic [CELL_W-1:0]     in_byte = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic                  out_valid;
    logic [CELL_W-1:0]     out_byte;
    logic                  input_taken;
    logic                  done_res;
    logic [ST_W-1:0]       status;
    logic [POS_W-1:0]      position;
    logic [HEAD_W-1:0]     head;
    logic [CELL_W-1:0]     cell_value;

    bf_run_tracker tracker;
    bit            no_idle;
    int            loaded_prefix;    // program bytes 0..loaded_prefix-1 are written
    int            work_done;
    int            stall_cycles;
    bit [7:0]      program_image[$];

    bf_instruction_executor_core dut (.*);

    always #5ns clk = ~clk;

    // Result side: random stalls unless idling is off
    always @(posedge clk)
        res_ready <= no_idle || ($urandom_range(99) >= 10);

    // Result monitor
    always @(posedge clk)
        if (rst_n && res_valid && res_ready)
            tracker.match_report(bf_report_t'({out_valid, out_byte, input_taken, done_res,
                                               status, position, head, cell_value}));

    // Watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (res_valid && res_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Present one input word and hold it until accepted
    task automatic send_word(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                             input logic [7:0] ib, input logic [7:0] inb);
        if (!no_idle && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
        in_valid <= 1'b1;
        kind <= k;
        address <= a;
        instr_byte <= ib;
        in_byte <= inb;
        do
            @(posedge clk);
        while (!in_ready);
        work_done += tracker.take_word(k, a, ib, inb);
    endtask

    task automatic send_exec();
        send_word(KIND_EXEC, ADDR_W'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_restart();
        send_word(KIND_RESTART, ADDR_W'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Drop valid and wait until every predicted result word has arrived
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outstanding() != 0);
    endtask

    // Write both registers; spare cfg_data bits above cell_init are random
    task automatic set_config(input int plen, input logic [7:0] init);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom);
        w[7:0] = init;
        cfg_we <= 1'b1;
        cfg_index <= CFG_PROG_LEN;
        cfg_data <= CFG_DATA_W'(plen);
        @(posedge clk);
        tracker.write_reg(CFG_PROG_LEN, CFG_DATA_W'(plen));
        cfg_index <= CFG_CELL_INIT;
        cfg_data <= w;
        @(posedge clk);
        tracker.write_reg(CFG_CELL_INIT, w);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] basic [9];
        logic [7:0] b;
        logic [7:0] init;
        int         order[$];
        int         j, r, len, plen, cap, steps, depth, left, episode;
        bit         broken;

        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty program, unknown kind, address/data extremes,
        // comma with 0xFF then wrap both ways, output, pointer underflow
        basic = '{8'h00, CH_COMMA, CH_PLUS, CH_DOT, CH_MINUS, CH_DOT,
                  CH_RIGHT, CH_LEFT, CH_LEFT};
        set_config(0, 8'hA5);
        send_exec();
        send_word(KIND_NOP, ADDR_W'($urandom), 8'($urandom), 8'($urandom));
        send_word(KIND_LOAD, 12'hFFF, 8'hFF, 8'h00);
        for (j = 0; j < 9; j++)
            send_word(KIND_LOAD, ADDR_W'(j), basic[j], 8'h00);
        loaded_prefix = 9;
        wait_idle();
        set_config(9, 8'hA5);
        send_restart();
        // last one runs into the halt
        for (j = 0; j < 10; j++)
            send_word(KIND_EXEC, ADDR_W'($urandom), 8'($urandom), 8'hFF);
        // ']' at 0 with a nonzero cell: no '[' behind it
        send_word(KIND_LOAD, 12'h000, CH_CLOSE, 8'h00);
        wait_idle();
        set_config(1, 8'hA5);
        send_restart();
        send_exec();

        // Random programs: mostly balanced brackets, some broken, mostly short
        work_done = 0;
        episode = 0;
        while (work_done < RANDOM_WORK)
        begin
            no_idle = (episode >= 4 && episode < 8);
            r = $urandom_range(99);
            if (r < 60)
                len = $urandom_range(16, 1);
            else if (r < 90)
                len = $urandom_range(48, 17);
            else
                len = $urandom_range(160, 49);
            broken = ($urandom_range(99) < 15);

            // build the program, closing open loops in time unless broken
            program_image.delete();
            depth = 0;
            for (j = 0; j < len; j++)
            begin
                left = len - j;
                r = $urandom_range(99);
                if (!broken && depth > 0 && left <= depth)
                    b = CH_CLOSE;
                else if (r < 18)
                    b = CH_PLUS;
                else if (r < 34)
                    b = CH_MINUS;
                else if (r < 44)
                    b = CH_DOT;
                else if (r < 52)
                    b = CH_COMMA;
                else if (r < 66)
                    b = CH_RIGHT;
                else if (r < 76)
                    b = CH_LEFT;
                else if (r < 86)
                    b = (broken || depth + 1 < left) ? CH_OPEN : CH_PLUS;
                else if (r < 95)
                    b = (broken || depth > 0) ? CH_CLOSE : CH_MINUS;
                else
                    b = 8'($urandom);
                if (b == CH_OPEN)
                    depth++;
                else if (b == CH_CLOSE && depth > 0)
                    depth--;
                program_image.insert(program_image.size(), b);
            end

            // load it, sometimes out of order
            order.delete();
            for (j = 0; j < len; j++)
                order.insert(order.size(), j);
            if ($urandom_range(1) == 1)
                order.shuffle();
            foreach (order[n])
                send_word(KIND_LOAD, ADDR_W'(order[n]), program_image[order[n]], 8'($urandom));
            if (len > loaded_prefix)
                loaded_prefix = len;

            // length stays within what has been written
            r = $urandom_range(99);
            if (r < 5)
                plen = 0;
            else if (r < 20)
                plen = $urandom_range(loaded_prefix, 0);
            else
                plen = len;
            r = $urandom_range(99);
            if (episode == 0 || r < 10)
                init = 8'hFF;
            else if (r < 50)
                init = 8'h00;
            else if (r < 70)
                init = 8'h01;
            else
                init = 8'($urandom);
            wait_idle();
            set_config(plen, init);
            send_restart();

            // run it, with stray loads, unknown kinds and restarts mixed in
            cap = (6 * len + 8 < 250) ? 6 * len + 8 : 250;
            for (steps = 0; steps < cap && !tracker.halted(); steps++)
            begin
                r = $urandom_range(99);
                if (r < 4)
                    send_word(KIND_NOP, ADDR_W'($urandom), 8'($urandom), 8'($urandom));
                else if (r < 7)
                    send_word(KIND_LOAD, ADDR_W'($urandom), 8'($urandom), 8'($urandom));
                else if (r < 9)
                    send_restart();
                else
                    send_exec();
            end
            if ($urandom_range(2) == 0)
                send_exec();
            episode++;
        end

        // Length past the store: done stays low until the pointer underflows
        send_word(KIND_LOAD, 12'h000, CH_PLUS, 8'h00);
        send_word(KIND_LOAD, 12'h001, CH_DOT, 8'h00);
        send_word(KIND_LOAD, 12'h002, CH_LEFT, 8'h00);
        wait_idle();
        set_config(LEN_FIELD_MAX, 8'h7F);
        send_restart();
        for (j = 0; j < 4; j++)
            send_exec();

        // drain and let any stray word show up
        wait_idle();
        repeat (16) @(posedge clk);
        if (tracker.fails == 0 && tracker.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
